// ===== design/fcct_pkg.sv =====
// ----------------------------------------------------------------------------
// fcct_pkg: shared types and constants for the four channel compare timer
// register indexes, reset values and the channel control bundle
// ----------------------------------------------------------------------------
package fcct_pkg;

  // default sizing of the timer
  localparam int unsigned NUM_CHANNELS_DEF = 4;
  localparam int unsigned COUNT_WIDTH_DEF  = 32;

  // channels that own a period register, the rest run on the reset period
  localparam int unsigned NUM_PERIOD_REGS = 4;

  // configuration port geometry
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;

  // fixed widths of the item fields
  localparam int unsigned CLEAR_W = 4;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned FLAGS_W = 4;

  // reset values
  localparam logic [CFG_DATA_W-1:0] PERIOD_RESET   = 32'h0000_ffff;
  localparam logic [CFG_DATA_W-1:0] PRESCALE_RESET = 32'h0000_0001;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESCALE_DIV,
    CFG_PERIOD_CH0,
    CFG_PERIOD_CH1,
    CFG_PERIOD_CH2,
    CFG_PERIOD_CH3,
    CFG_IRQ_ENABLE,
    CFG_RUN_ENABLE
  } cfg_idx_e;

  // per channel control from the top level
  typedef struct packed {
    logic load;     // period write: load period and compare value
    logic advance;  // counter steps on this item
    logic enable;   // channel enabled for matching
  } ch_ctrl_t;

endpackage

// ===== design/fcct_channel.sv =====
// ----------------------------------------------------------------------------
// fcct_channel: one compare channel
// holds the period and the compare value, flags a match against the next
// counter value and rearms the compare value by the period
// ----------------------------------------------------------------------------
module fcct_channel #(
  parameter int unsigned COUNT_WIDTH = fcct_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fcct_pkg::ch_ctrl_t              ctrl_i,
  input  logic [fcct_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [COUNT_WIDTH-1:0]          count_next_i,
  output logic                            hit_o
);
  import fcct_pkg::*;

  logic [CFG_DATA_W-1:0]  period_q;
  logic [COUNT_WIDTH-1:0] compare_q;
  logic [COUNT_WIDTH-1:0] period_ext;

  assign period_ext = COUNT_WIDTH'(period_q);

  // match on the value the counter steps onto
  assign hit_o = ctrl_i.advance && ctrl_i.enable && (compare_q == count_next_i);

  // period register and compare value with rearm, wrapping at the counter width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= PERIOD_RESET;
      compare_q <= COUNT_WIDTH'(PERIOD_RESET);
    end else if (ctrl_i.load) begin
      period_q  <= cfg_data_i;
      compare_q <= COUNT_WIDTH'(cfg_data_i);
    end else if (hit_o) begin
      compare_q <= compare_q + period_ext;
    end
  end

endmodule

// ===== design/four_channel_compare_timer.sv =====
// ----------------------------------------------------------------------------
// four_channel_compare_timer: prescaled up counter with periodic compare
// channels; each item is one tick carrying a write-one-to-clear pending mask
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  -------   -------------------------  ---------------------------------------
//  in        in_valid_i / in_ready_o    clear_mask_i
//  out       out_valid_o / out_ready_i  count_value_o, match_hit_o,
//                                       pending_flags_o, irq_out_o
//  config    cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
//  one item per clock unless the output stalls: the tick updates prescaler,
//  counter, compare values and pending flags at acceptance, and the result
//  is registered in the output register; the output register takes a new
//  item in the same cycle its result leaves; a stalled output holds its item
//  and stops intake; reset is asynchronous and clears all state but the
//  output payload to the register reset values
// ----------------------------------------------------------------------------
module four_channel_compare_timer #(
  parameter int unsigned NUM_CHANNELS = fcct_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned COUNT_WIDTH  = fcct_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [fcct_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fcct_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // tick items
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [fcct_pkg::CLEAR_W-1:0]    clear_mask_i,
  // results
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [fcct_pkg::VALUE_W-1:0]    count_value_o,
  output logic [fcct_pkg::FLAGS_W-1:0]    match_hit_o,
  output logic [fcct_pkg::FLAGS_W-1:0]    pending_flags_o,
  output logic                            irq_out_o
);
  import fcct_pkg::*;

  // configuration registers
  logic [CFG_DATA_W-1:0]   prescale_div_q;
  logic [NUM_CHANNELS-1:0] irq_en_q;
  logic                    run_q;

  // timer state
  logic [CFG_DATA_W-1:0]   prescale_q, prescale_d;
  logic [COUNT_WIDTH-1:0]  counter_q, counter_d;
  logic [NUM_CHANNELS-1:0] pending_q, pending_d;

  // output register
  logic                    out_valid_q;
  logic [VALUE_W-1:0]      out_count_q;
  logic [FLAGS_W-1:0]      out_hit_q;
  logic [FLAGS_W-1:0]      out_pend_q;
  logic                    out_irq_q;

  logic                    accept;
  logic                    wrap;
  logic                    advance;
  logic [CFG_DATA_W-1:0]   limit;
  logic [NUM_CHANNELS-1:0] hit_vec;
  ch_ctrl_t                ch_ctrl [NUM_CHANNELS];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_div_q <= PRESCALE_RESET;
      irq_en_q       <= '0;
      run_q          <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRESCALE_DIV: prescale_div_q <= cfg_data_i;
        CFG_IRQ_ENABLE:   irq_en_q       <= NUM_CHANNELS'(cfg_data_i);
        CFG_RUN_ENABLE:   run_q          <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  // prescaler: a zero divisor behaves as one
  assign limit   = (prescale_div_q == '0) ? '0 : prescale_div_q - 1'b1;
  assign wrap    = (prescale_q >= limit);
  assign advance = run_q && wrap;

  always_comb begin
    prescale_d = prescale_q;
    counter_d  = counter_q;
    if (run_q) begin
      if (wrap) begin
        prescale_d = '0;
        counter_d  = counter_q + 1'b1;
      end else begin
        prescale_d = prescale_q + 1'b1;
      end
    end
  end

  // compare channels
  for (genvar n = 0; n < NUM_CHANNELS; n++) begin : g_ch
    if (n < NUM_PERIOD_REGS) begin : g_load
      assign ch_ctrl[n].load = cfg_we_i &&
        (cfg_idx_i == CFG_IDX_W'(CFG_PERIOD_CH0) + CFG_IDX_W'(n));
    end else begin : g_noload
      assign ch_ctrl[n].load = 1'b0;
    end
    assign ch_ctrl[n].advance = accept && advance;
    assign ch_ctrl[n].enable  = irq_en_q[n];

    fcct_channel #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_channel (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ch_ctrl[n]),
      .cfg_data_i  (cfg_data_i),
      .count_next_i(counter_d),
      .hit_o       (hit_vec[n])
    );
  end

  // clear first, then set on match
  assign pending_d = (pending_q & ~NUM_CHANNELS'(clear_mask_i)) | hit_vec;

  // timer state update per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= '0;
      counter_q  <= '0;
      pending_q  <= '0;
    end else if (accept) begin
      prescale_q <= prescale_d;
      counter_q  <= counter_d;
      pending_q  <= pending_d;
    end
  end

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_count_q <= VALUE_W'(counter_d);
      out_hit_q   <= FLAGS_W'(hit_vec);
      out_pend_q  <= FLAGS_W'(pending_d);
      out_irq_q   <= |pending_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign count_value_o   = out_count_q;
  assign match_hit_o     = out_hit_q;
  assign pending_flags_o = out_pend_q;
  assign irq_out_o       = out_irq_q;

  // counter steps by one on a running wrap
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && advance |=> counter_q == $past(counter_q) + 1'b1)
    else $error("counter did not step on prescaler wrap");

  // no match without a counter step
  a_hit_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_vec != '0 |-> accept && advance)
    else $error("match flagged without counter step");

  // a matched channel is pending after the item
  a_hit_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (pending_q & $past(hit_vec)) == $past(hit_vec))
    else $error("matched channel not pending");

  // timer state holds between items
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(counter_q) && $stable(prescale_q) && $stable(pending_q))
    else $error("timer state changed without an item");

  // visible pending flags imply the interrupt
  a_irq_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_pend_q != '0 |-> out_irq_q)
    else $error("pending flags without interrupt");

endmodule
